// ===== src/serial_frame_to_controller_report_defines.svh =====
// Assertion helpers shared by the frame report RTL.
`ifndef SERIAL_FRAME_TO_CONTROLLER_REPORT_DEFINES_SVH
`define SERIAL_FRAME_TO_CONTROLLER_REPORT_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define SFCR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Property checked in the cycle after a trigger, outside reset.
`define SFCR_ASSERT_NEXT(name, trig, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

// ===== src/sfcr_pkg.sv =====
package sfcr_pkg;

  localparam int MAX_PAYLOAD = 16;
  localparam int POS_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int RAM_ROWS    = (MAX_PAYLOAD + 7) / 8;
  localparam int RAM_AW      = (RAM_ROWS > 1) ? $clog2(RAM_ROWS) : 1;

  localparam logic [POS_W-1:0] MAX_POS      = POS_W'(MAX_PAYLOAD);
  localparam logic [7:0]       MAX_LEN_BYTE = 8'(MAX_PAYLOAD);

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;
  localparam logic [7:0] TAG_ACK2    = 8'h93;
  localparam logic [7:0] TAG_ACK8    = 8'h92;
  localparam logic [7:0] TAG_CTRL    = 8'hA1;

  localparam logic [POS_W-1:0] LEN_ACK2 = POS_W'(3);
  localparam logic [POS_W-1:0] LEN_ACK8 = POS_W'(9);
  localparam logic [POS_W-1:0] LEN_CTRL = POS_W'(6);

  localparam logic [7:0] BTN_BAD_MASK = 8'hF0;
  localparam logic [3:0] OPT_MASK     = 4'hC;

  localparam logic [3:0]  CONFIRM_RESET = 4'd3;
  localparam logic [9:0]  LEVER_RESET   = 10'd350;
  localparam logic [9:0]  LEVER_BASE    = 10'd100;
  localparam logic [16:0] LEVER_ROUND   = 17'd127;
  // 32897 / 2^23 is 1/255 closely enough for an exact quotient of every
  // x*500 + 127 with x a byte (remainders there never exceed 252)
  localparam logic [32:0] RECIP_255     = 33'd32897;
  localparam int          RECIP_SHIFT   = 23;

  localparam logic [2:0] FS_USED    = 3'd0;
  localparam logic [2:0] FS_UNUSED  = 3'd1;
  localparam logic [2:0] FS_CSUM    = 3'd2;
  localparam logic [2:0] FS_BADLEN  = 3'd3;
  localparam logic [2:0] FS_BADBTN  = 3'd4;
  localparam logic [2:0] FS_ACKHELD = 3'd5;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_CTRL = 2'd1;
  localparam logic [1:0] KIND_ACK8 = 2'd2;
  localparam logic [1:0] KIND_ACK2 = 2'd3;

  typedef enum logic [2:0] {
    DF_SYNC1,
    DF_SYNC2,
    DF_LEN,
    DF_DATA,
    DF_SUM
  } df_state_t;

  typedef struct packed {
    logic             take;
    logic             fin;
    logic             bad_len;
    logic             bad_sum;
    logic [POS_W-1:0] len;
  } frm_evt_t;

  typedef struct packed {
    logic [2:0]  frame_status;
    logic [1:0]  host_report_kind;
    logic [63:0] host_payload;
    logic        game_report_updated;
    logic [7:0]  game_buttons_low;
    logic [7:0]  game_buttons_high;
    logic [9:0]  lever_value;
    logic [7:0]  raw_high_buttons;
    logic [15:0] valid_frame_count;
    logic [15:0] invalid_frame_count;
  } out_item_t;

endpackage

// ===== src/sfcr_if.sv =====
interface sfcr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface sfcr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  frame_status;
  logic [1:0]  host_report_kind;
  logic [63:0] host_payload;
  logic        game_report_updated;
  logic [7:0]  game_buttons_low;
  logic [7:0]  game_buttons_high;
  logic [9:0]  lever_value;
  logic [7:0]  raw_high_buttons;
  logic [15:0] valid_frame_count;
  logic [15:0] invalid_frame_count;

  modport source (
    output valid, output frame_status, output host_report_kind, output host_payload,
    output game_report_updated, output game_buttons_low, output game_buttons_high,
    output lever_value, output raw_high_buttons, output valid_frame_count,
    output invalid_frame_count, input ready
  );
  modport sink (
    input valid, input frame_status, input host_report_kind, input host_payload,
    input game_report_updated, input game_buttons_low, input game_buttons_high,
    input lever_value, input raw_high_buttons, input valid_frame_count,
    input invalid_frame_count, output ready
  );
endinterface

// ===== src/sfcr_payload_ram.sv =====
// Payload store: rows of eight byte lanes, one byte written per cycle.
// Rows 0 and 1 are read every cycle; the read register sees a write of the
// same cycle, so a frame's last byte is visible at the next transfer.
module sfcr_payload_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [sfcr_pkg::POS_W-1:0] addr,
  input  logic [7:0]                wdata,
  output logic [63:0]               row0_q,
  output logic [63:0]               row1_q
);

  logic [63:0] mem_r [sfcr_pkg::RAM_ROWS];
  logic [63:0] row0_r, row1_r;
  logic [63:0] row0_nxt, row1_nxt;
  logic [sfcr_pkg::RAM_AW-1:0] row;
  logic [2:0] lane;

  assign row  = addr[3 +: sfcr_pkg::RAM_AW];
  assign lane = addr[2:0];

  always_comb begin
    row0_nxt = mem_r[0];
    row1_nxt = mem_r[1];
    if (we && row == sfcr_pkg::RAM_AW'(0)) begin
      row0_nxt[{lane, 3'b000} +: 8] = wdata;
    end
    if (we && row == sfcr_pkg::RAM_AW'(1)) begin
      row1_nxt[{lane, 3'b000} +: 8] = wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[row][{lane, 3'b000} +: 8] <= wdata;
    end
    row0_r <= row0_nxt;
    row1_r <= row1_nxt;
  end

  assign row0_q = row0_r;
  assign row1_q = row1_r;

endmodule

// ===== src/sfcr_deframer.sv =====
`include "serial_frame_to_controller_report_defines.svh"

module sfcr_deframer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc,
  input  logic                       mode,
  input  logic [7:0]                 data_byte,
  output logic                       ram_we,
  output logic [sfcr_pkg::POS_W-1:0] ram_addr,
  output logic [7:0]                 ram_wdata,
  output sfcr_pkg::frm_evt_t         evt
);

  sfcr_pkg::df_state_t state_r, state_nxt, resync;
  logic [sfcr_pkg::POS_W-1:0] len_r, len_nxt;
  logic [sfcr_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0] xor_r, xor_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfcr_pkg::DF_SYNC1;
      len_r   <= '0;
      pos_r   <= '0;
      xor_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      xor_r   <= xor_nxt;
    end
  end

  // a rejected byte that is itself the first sync byte (AA) starts the next frame
  assign resync = (data_byte == sfcr_pkg::SYNC_FIRST) ? sfcr_pkg::DF_SYNC2
                                                      : sfcr_pkg::DF_SYNC1;

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    xor_nxt   = xor_r;
    ram_we    = 1'b0;
    ram_addr  = pos_r;
    ram_wdata = data_byte;
    evt       = '0;
    evt.len   = len_r;
    if (acc && mode) begin
      evt.take = 1'b1;
    end else if (acc) begin
      case (state_r)
        sfcr_pkg::DF_SYNC1: begin
          if (data_byte == sfcr_pkg::SYNC_FIRST) state_nxt = sfcr_pkg::DF_SYNC2;
        end
        sfcr_pkg::DF_SYNC2: begin
          if (data_byte == sfcr_pkg::SYNC_SECOND) begin
            state_nxt = sfcr_pkg::DF_LEN;
          end else if (data_byte != sfcr_pkg::SYNC_FIRST) begin
            state_nxt = sfcr_pkg::DF_SYNC1;
          end
        end
        sfcr_pkg::DF_LEN: begin
          if (data_byte == 8'd0 || data_byte > sfcr_pkg::MAX_LEN_BYTE) begin
            evt.fin     = 1'b1;
            evt.bad_len = 1'b1;
            state_nxt   = resync;
          end else begin
            len_nxt   = data_byte[sfcr_pkg::POS_W-1:0];
            pos_nxt   = '0;
            xor_nxt   = '0;
            state_nxt = sfcr_pkg::DF_DATA;
          end
        end
        sfcr_pkg::DF_DATA: begin
          ram_we  = (pos_r < sfcr_pkg::MAX_POS);
          pos_nxt = pos_r + 1'b1;
          xor_nxt = xor_r ^ data_byte;
          if (pos_nxt == len_r) state_nxt = sfcr_pkg::DF_SUM;
        end
        sfcr_pkg::DF_SUM: begin
          evt.fin = 1'b1;
          if (data_byte != xor_r) begin
            evt.bad_sum = 1'b1;
            state_nxt   = resync;
          end else begin
            state_nxt = sfcr_pkg::DF_SYNC1;
          end
        end
        default: state_nxt = sfcr_pkg::DF_SYNC1;
      endcase
    end
  end

  `SFCR_ASSERT(a_data_pos, state_r == sfcr_pkg::DF_DATA |-> pos_r < len_r, "data position past length")
  `SFCR_ASSERT(a_sum_pos, state_r == sfcr_pkg::DF_SUM |-> pos_r == len_r && len_r != '0, "checksum state with short frame")
  `SFCR_ASSERT_NEXT(a_badlen_sync, evt.bad_len, state_r == sfcr_pkg::DF_SYNC1 || state_r == sfcr_pkg::DF_SYNC2, "bad length did not resync")

endmodule

// ===== src/sfcr_report.sv =====
`include "serial_frame_to_controller_report_defines.svh"

module sfcr_report (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    acc,
  input  sfcr_pkg::frm_evt_t      evt,
  input  logic [63:0]             row0,
  input  logic [63:0]             row1,
  input  logic                    cfg_we,
  input  logic [3:0]              cfg_wdata,
  input  logic                    out_ready,
  output logic                    out_valid,
  output sfcr_pkg::out_item_t     out_item
);

  logic [3:0]  cfm_r;
  logic [15:0] good_r, good_nxt, bad_r, bad_nxt;
  logic        pend_r, pend_nxt;
  logic [1:0]  held_r, held_nxt;
  logic [3:0]  cand_r, cand_nxt, mcnt_r, mcnt_nxt, pub_r, pub_nxt;
  logic [7:0]  glow_r, glow_nxt, ghigh_r, ghigh_nxt, graw_r, graw_nxt;
  logic [9:0]  glever_r, glever_nxt;
  logic        out_valid_r, out_valid_nxt;
  sfcr_pkg::out_item_t out_r, out_nxt;

  logic [7:0]  tag, b2, b3, b5;
  logic [63:0] bytes;
  logic [3:0]  opt, o_cand, o_cnt, o_pub;
  logic [16:0] lv_v;
  logic [32:0] lv_p;
  logic [9:0]  lever_new;
  logic        fin, good_frame, is_ctrl, is_ack2, is_ack8, bad_btn, ack_held;
  logic [2:0]  status;
  logic [1:0]  kind;
  logic [63:0] payload;
  logic        refresh;

  assign tag   = row0[7:0];
  assign b2    = row0[23:16];
  assign b3    = row0[31:24];
  assign b5    = row0[47:40];
  assign bytes = {row1[7:0], row0[63:8]};

  assign fin        = acc && evt.fin;
  assign good_frame = fin && !evt.bad_len && !evt.bad_sum;
  assign is_ctrl    = evt.len == sfcr_pkg::LEN_CTRL && tag == sfcr_pkg::TAG_CTRL;
  assign is_ack2    = evt.len == sfcr_pkg::LEN_ACK2 && tag == sfcr_pkg::TAG_ACK2;
  assign is_ack8    = evt.len == sfcr_pkg::LEN_ACK8 && tag == sfcr_pkg::TAG_ACK8;
  assign bad_btn    = is_ctrl && ((b3 & sfcr_pkg::BTN_BAD_MASK) != 8'd0);
  assign ack_held   = pend_r && (held_r == sfcr_pkg::KIND_ACK8 ||
                                 held_r == sfcr_pkg::KIND_ACK2);

  // lever: 100 + (x*500 + 127) / 255, x*500 as shift-adds
  assign lv_v = {b5, 9'b0} - {6'b0, b5, 3'b0} - {7'b0, b5, 2'b0} + sfcr_pkg::LEVER_ROUND;
  assign lv_p = {16'b0, lv_v} * sfcr_pkg::RECIP_255;
  assign lever_new = sfcr_pkg::LEVER_BASE + lv_p[sfcr_pkg::RECIP_SHIFT +: 10];

  assign opt = b3[3:0] & sfcr_pkg::OPT_MASK;

  always_comb begin
    o_cand = cand_r;
    o_cnt  = mcnt_r;
    o_pub  = pub_r;
    if (opt != cand_r) begin
      o_cand = opt;
      o_cnt  = 4'd1;
    end else if (mcnt_r < cfm_r) begin
      o_cnt = mcnt_r + 4'd1;
    end
    if (o_cnt >= cfm_r) o_pub = o_cand;
  end

  always_comb begin
    status  = sfcr_pkg::FS_USED;
    kind    = sfcr_pkg::KIND_NONE;
    payload = '0;
    refresh = 1'b0;
    if (evt.bad_len) begin
      status = sfcr_pkg::FS_BADLEN;
    end else if (evt.bad_sum) begin
      status = sfcr_pkg::FS_CSUM;
    end else if (bad_btn) begin
      status = sfcr_pkg::FS_BADBTN;
    end else if (is_ack2) begin
      kind    = sfcr_pkg::KIND_ACK2;
      payload = {48'b0, bytes[15:0]};
    end else if (is_ack8) begin
      kind    = sfcr_pkg::KIND_ACK8;
      payload = bytes;
    end else if (!is_ctrl) begin
      status = sfcr_pkg::FS_UNUSED;
    end else if (ack_held) begin
      status = sfcr_pkg::FS_ACKHELD;
    end else begin
      kind    = sfcr_pkg::KIND_CTRL;
      payload = {24'b0, bytes[39:0]};
      refresh = 1'b1;
    end
  end

  always_comb begin
    good_nxt   = good_r;
    bad_nxt    = bad_r;
    pend_nxt   = pend_r;
    held_nxt   = held_r;
    cand_nxt   = cand_r;
    mcnt_nxt   = mcnt_r;
    pub_nxt    = pub_r;
    glow_nxt   = glow_r;
    ghigh_nxt  = ghigh_r;
    glever_nxt = glever_r;
    graw_nxt   = graw_r;
    if (acc && evt.take) pend_nxt = 1'b0;
    if (fin) begin
      if (good_frame && !bad_btn) begin
        if (good_r != 16'hFFFF) good_nxt = good_r + 16'd1;
      end else if (bad_r != 16'hFFFF) begin
        bad_nxt = bad_r + 16'd1;
      end
      if (good_frame && kind != sfcr_pkg::KIND_NONE) begin
        pend_nxt = 1'b1;
        held_nxt = kind;
      end
      if (good_frame && refresh) begin
        cand_nxt   = o_cand;
        mcnt_nxt   = o_cnt;
        pub_nxt    = o_pub;
        glow_nxt   = {2'b00, b2[0], b2[1], b2[2], b2[3], b2[4], b2[5]};
        ghigh_nxt  = {b3[0], b3[1], b2[6], b2[7], o_pub[2], o_pub[3], 2'b00};
        glever_nxt = lever_new;
        graw_nxt   = b3;
      end
    end
  end

  always_comb begin
    out_nxt                     = out_r;
    out_valid_nxt               = out_valid_r && !out_ready;
    if (fin) begin
      out_valid_nxt                  = 1'b1;
      out_nxt.frame_status           = status;
      out_nxt.host_report_kind       = good_frame ? kind : sfcr_pkg::KIND_NONE;
      out_nxt.host_payload           = good_frame ? payload : 64'd0;
      out_nxt.game_report_updated    = good_frame && refresh;
      out_nxt.game_buttons_low       = glow_nxt;
      out_nxt.game_buttons_high      = ghigh_nxt;
      out_nxt.lever_value            = glever_nxt;
      out_nxt.raw_high_buttons       = graw_nxt;
      out_nxt.valid_frame_count      = good_nxt;
      out_nxt.invalid_frame_count    = bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfm_r       <= sfcr_pkg::CONFIRM_RESET;
      good_r      <= '0;
      bad_r       <= '0;
      pend_r      <= 1'b1;
      held_r      <= sfcr_pkg::KIND_CTRL;
      cand_r      <= '0;
      mcnt_r      <= '0;
      pub_r       <= '0;
      glow_r      <= '0;
      ghigh_r     <= '0;
      glever_r    <= sfcr_pkg::LEVER_RESET;
      graw_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cfm_r <= cfg_wdata;
      good_r      <= good_nxt;
      bad_r       <= bad_nxt;
      pend_r      <= pend_nxt;
      held_r      <= held_nxt;
      cand_r      <= cand_nxt;
      mcnt_r      <= mcnt_nxt;
      pub_r       <= pub_nxt;
      glow_r      <= glow_nxt;
      ghigh_r     <= ghigh_nxt;
      glever_r    <= glever_nxt;
      graw_r      <= graw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `SFCR_ASSERT(a_upd_ctrl, out_valid_r && out_r.game_report_updated |-> out_r.host_report_kind == sfcr_pkg::KIND_CTRL && out_r.frame_status == sfcr_pkg::FS_USED, "game update without controller report")
  `SFCR_ASSERT(a_none_zero, out_valid_r && out_r.host_report_kind == sfcr_pkg::KIND_NONE |-> out_r.host_payload == 64'd0, "payload on unchanged host report")
  `SFCR_ASSERT(a_cnt_mono, $past(rst_n) |-> good_r >= $past(good_r) && bad_r >= $past(bad_r), "frame count went down")
  `SFCR_ASSERT_NEXT(a_take_clear, acc && evt.take, !pend_r, "host take left report pending")

endmodule

// ===== src/serial_frame_to_controller_report.sv =====
// Serial frame deframer with controller report builder.
// in_ch carries one transfer per received serial byte (mode 0) or a
// "host took the pending report" notice (mode 1). Frames are AA 55 LEN
// PAYLOAD[LEN] XOR with LEN 1..16; the deframer resyncs on AA.
// out_ch carries one result per frame end: an accepted frame, a checksum
// error or a bad length. The result is registered and is valid the cycle
// after the transfer of the checksum or length byte; other bytes give none.
// Throughput is one byte per cycle unless out_ch stalls: the state sits in
// flops and a 2-row payload RAM whose registered read forwards the byte written
// alongside. When the receiver stalls, the output register holds its result and
// in_ch.ready stays low until out_ch takes it.
// cfg_we/cfg_wdata set confirm_frames, the number of equal controller
// frames needed before test/service bits are published.
// Synchronous reset (rst_n low): deframer waits for AA, counts are zero,
// lever reads 350, confirm_frames is 3, the host report counts as pending.
// No clearing pass: payload bytes are always written before they are read.
module serial_frame_to_controller_report (
  input  logic              clk,
  input  logic              rst_n,
  sfcr_in_if.sink           in_ch,
  sfcr_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata
);

  logic                       acc;
  logic                       ram_we;
  logic [sfcr_pkg::POS_W-1:0] ram_addr;
  logic [7:0]                 ram_wdata;
  logic [63:0]                row0, row1;
  sfcr_pkg::frm_evt_t         evt;
  logic                       rpt_valid;
  sfcr_pkg::out_item_t        rpt_item;

  assign in_ch.ready = !rpt_valid || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;

  sfcr_deframer u_deframer (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .mode      (in_ch.mode),
    .data_byte (in_ch.data_byte),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .evt       (evt)
  );

  sfcr_payload_ram u_ram (
    .clk    (clk),
    .we     (ram_we),
    .addr   (ram_addr),
    .wdata  (ram_wdata),
    .row0_q (row0),
    .row1_q (row1)
  );

  sfcr_report u_report (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .evt       (evt),
    .row0      (row0),
    .row1      (row1),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_ch.ready),
    .out_valid (rpt_valid),
    .out_item  (rpt_item)
  );

  assign out_ch.valid               = rpt_valid;
  assign out_ch.frame_status        = rpt_item.frame_status;
  assign out_ch.host_report_kind    = rpt_item.host_report_kind;
  assign out_ch.host_payload        = rpt_item.host_payload;
  assign out_ch.game_report_updated = rpt_item.game_report_updated;
  assign out_ch.game_buttons_low    = rpt_item.game_buttons_low;
  assign out_ch.game_buttons_high   = rpt_item.game_buttons_high;
  assign out_ch.lever_value         = rpt_item.lever_value;
  assign out_ch.raw_high_buttons    = rpt_item.raw_high_buttons;
  assign out_ch.valid_frame_count   = rpt_item.valid_frame_count;
  assign out_ch.invalid_frame_count = rpt_item.invalid_frame_count;

endmodule
